FILE: src/fully_associative_cache_random_replace_core_macros.svh
// assertion macros for the fully associative cache core
`ifndef FULLY_ASSOCIATIVE_CACHE_RANDOM_REPLACE_CORE_MACROS_SVH
`define FULLY_ASSOCIATIVE_CACHE_RANDOM_REPLACE_CORE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define FACR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("facr assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define FACR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("facr assertion failed");

`endif

FILE: src/facr_pkg.sv
// types, constants and a helper function shared by the cache core
`timescale 1ns / 1ps
`default_nettype none

package facr_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = IDX_W + 1;
	localparam int ADDR_W  = 16;
	localparam int TAG_W   = 16;
	localparam int DATA_W  = 31;
	localparam int OFF_W   = 4;
	localparam int SLOT_W  = 6;
	localparam int LFSR_W  = 16;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_LAUNCH,
		ST_WALK,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic              active;
		logic              op;
		logic [TAG_W-1:0]  tag;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  target;
		logic              evict;
		logic              found;
		logic [DATA_W-1:0] rdata;
		logic [IDX_W-1:0]  slot;
		logic [TAG_W-1:0]  ev_tag;
		logic [DATA_W-1:0] ev_data;
	} rec_t;

	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic fb;
		fb = v[15] ^ v[13] ^ v[12] ^ v[10];
		return {v[LFSR_W-2:0], fb};
	endfunction

endpackage

`default_nettype wire

FILE: src/facr_cell.sv
// one cache entry of the chain, checks and updates the passing request record
`timescale 1ns / 1ps
`default_nettype none

module facr_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [facr_pkg::IDX_W-1:0] idx,
	input  wire facr_pkg::rec_t    rec_in,
	output facr_pkg::rec_t         rec_out
);
	import facr_pkg::*;

	logic              valid_q;
	logic [TAG_W-1:0]  tag_q;
	logic [DATA_W-1:0] data_q;
	rec_t              rec_q;
	rec_t              rec_nxt;
	logic              wr_en;

	assign wr_en = rec_in.active && (rec_in.op == OP_WRITE) && (rec_in.target == idx);

	always_comb begin
		rec_nxt = rec_in;
		if (rec_in.active) begin
			if (rec_in.op == OP_READ) begin
				if (!rec_in.found && valid_q && (tag_q == rec_in.tag)) begin
					rec_nxt.found = 1'b1;
					rec_nxt.rdata = data_q;
					rec_nxt.slot  = idx;
				end
			end else if (rec_in.target == idx) begin
				rec_nxt.ev_tag  = tag_q;
				rec_nxt.ev_data = data_q;
				rec_nxt.slot    = idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rec_q   <= '0;
		end else begin
			rec_q <= rec_nxt;
			if (wr_en) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_q  <= rec_in.tag;
			data_q <= rec_in.wdata;
		end
	end

	assign rec_out = rec_q;

endmodule

`default_nettype wire

FILE: src/facr_rem.sv
// victim index register, the advanced lfsr value modulo the entry count
`timescale 1ns / 1ps
`default_nettype none

module facr_rem (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [facr_pkg::LFSR_W-1:0]  dividend,
	output logic                              done,
	output logic [facr_pkg::IDX_W-1:0]        rem
);
	import facr_pkg::*;

	localparam logic [LFSR_W-1:0] MODULUS = LFSR_W'(ENTRIES);

	logic              done_q;
	logic [IDX_W-1:0]  rem_q;
	logic [LFSR_W-1:0] rem_full;

	assign rem_full = dividend % MODULUS;
	assign done     = done_q;
	assign rem      = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_full[IDX_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: src/fully_associative_cache_random_replace_core.sv
// top level of the fully associative cache with random replacement
`timescale 1ns / 1ps
`default_nettype none

// Fully associative cache of ENTRIES entries held in a chain of cells, one entry per
// cell. A transfer on the input side is a read lookup or a write fill; the request
// record walks the chain one cell per cycle, each cell comparing its tag or storing
// the write as the record passes, so the lowest matching or lowest free entry wins.
// One item is in flight at a time: a read or a write into a free entry passes through
// launch and chain walk, then capture and output load; a write into a full cache
// first passes through an extra state (ST_MOD) once the victim
// index, the advanced 16-bit lfsr modulo ENTRIES, is registered. The next input is
// taken as soon as the result sits in the output register, even while that result
// is stalled. offset_bits must only be written while no item is in flight.
`include "fully_associative_cache_random_replace_core_macros.svh"

module fully_associative_cache_random_replace_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [facr_pkg::OFF_W-1:0]    cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          op,
	input  wire logic [facr_pkg::ADDR_W-1:0]   address,
	input  wire logic [facr_pkg::DATA_W-1:0]   write_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               hit,
	output logic [facr_pkg::DATA_W-1:0]        read_data,
	output logic                               evicted,
	output logic [facr_pkg::TAG_W-1:0]         evicted_tag,
	output logic [facr_pkg::DATA_W-1:0]        evicted_data,
	output logic [facr_pkg::SLOT_W-1:0]        slot
);
	import facr_pkg::*;

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

	state_t            state_q;
	state_t            state_nxt;
	logic [OFF_W-1:0]  offset_bits_q;
	logic [CNT_W-1:0]  count_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] lfsr_adv;

	logic              req_op_q;
	logic [TAG_W-1:0]  req_tag_q;
	logic [DATA_W-1:0] req_wdata_q;
	logic              req_evict_q;
	logic [IDX_W-1:0]  target_q;

	logic              accept;
	logic              full;
	logic              evict_now;
	logic              launch;
	logic              capture;
	logic              load_out;
	logic              out_free;
	logic              rem_done;
	logic [IDX_W-1:0]  rem_idx;
	logic [TAG_W-1:0]  acc_tag;

	rec_t              chain_w [ENTRIES+1];
	rec_t              tail;
	rec_t              res_q;
	logic [IDX_W+SLOT_W-1:0] slot_wide;

	logic              out_valid_q;
	logic              hit_q;
	logic [DATA_W-1:0] read_data_q;
	logic              evicted_q;
	logic [TAG_W-1:0]  evicted_tag_q;
	logic [DATA_W-1:0] evicted_data_q;
	logic [SLOT_W-1:0] slot_q;

	assign full      = (count_q == FULL_COUNT);
	assign accept    = in_valid && !in_stall;
	assign evict_now = (op == OP_WRITE) && full;
	assign lfsr_adv  = lfsr_next(lfsr_q);
	assign acc_tag   = address >> offset_bits_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign tail      = chain_w[ENTRIES];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = evict_now ? ST_MOD : ST_LAUNCH;
				end
			end
			ST_MOD: begin
				if (rem_done) begin
					state_nxt = ST_LAUNCH;
				end
			end
			ST_LAUNCH: begin
				state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (tail.active) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// fsm outputs
	always_comb begin
		in_stall = 1'b1;
		launch   = 1'b0;
		capture  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_MOD: begin
				in_stall = 1'b1;
			end
			ST_LAUNCH: begin
				launch = 1'b1;
			end
			ST_WALK: begin
				capture = tail.active;
			end
			ST_DRAIN: begin
				load_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			offset_bits_q <= '0;
			count_q       <= '0;
			lfsr_q        <= LFSR_SEED;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				offset_bits_q <= cfg_wr_data;
			end
			if (accept && (op == OP_WRITE)) begin
				if (full) begin
					lfsr_q <= lfsr_adv;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q    <= op;
			req_tag_q   <= acc_tag;
			req_wdata_q <= write_data;
			req_evict_q <= evict_now;
			target_q    <= count_q[IDX_W-1:0];
		end
	end

	facr_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && evict_now),
		.dividend (lfsr_adv),
		.done     (rem_done),
		.rem      (rem_idx)
	);

	// request record entering the chain
	always_comb begin
		chain_w[0]         = '0;
		chain_w[0].active  = launch;
		chain_w[0].op      = req_op_q;
		chain_w[0].tag     = req_tag_q;
		chain_w[0].wdata   = req_wdata_q;
		chain_w[0].target  = req_evict_q ? rem_idx : target_q;
		chain_w[0].evict   = req_evict_q;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		facr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.rec_in  (chain_w[i]),
			.rec_out (chain_w[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			res_q <= tail;
		end
	end

	assign slot_wide = {{SLOT_W{1'b0}}, res_q.slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_q          <= (res_q.op == OP_READ) && res_q.found;
			read_data_q    <= res_q.rdata;
			evicted_q      <= res_q.evict;
			evicted_tag_q  <= res_q.evict ? res_q.ev_tag : '0;
			evicted_data_q <= res_q.evict ? res_q.ev_data : '0;
			slot_q         <= slot_wide[SLOT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign read_data    = read_data_q;
	assign evicted      = evicted_q;
	assign evicted_tag  = evicted_tag_q;
	assign evicted_data = evicted_data_q;
	assign slot         = slot_q;

	`FACR_ASSERT_IMP(a_tail_only_in_walk, tail.active, state_q == ST_WALK)
	`FACR_ASSERT_IMP(a_count_bounded, 1'b1, count_q <= FULL_COUNT)
	`FACR_ASSERT_IMP(a_evict_needs_full, out_valid && evicted, full)
	`FACR_ASSERT_NXT(a_launch_enters_chain, launch, chain_w[1].active)

endmodule

`default_nettype wire
